// ===== design/pfb_pkg.sv =====
// pfb_pkg: shared types and constants for the page frame buffer blitter
// no dependencies; imported by the top level, pfb_front and pfb_back
`timescale 1ns / 1ps

package pfb_pkg;

  // default store geometry
  localparam int PFB_PAGES       = 8;
  localparam int PFB_COLUMNS     = 128;

  // depth of the command queue between front and back
  localparam int PFB_QUEUE_DEPTH = 2;

  // fixed widths that follow from the input and config fields
  localparam int PFB_BYTE_W      = 8;
  localparam int PFB_PG_W        = 4;   // store page, up to sixteen pages
  localparam int PFB_COL_W       = 8;   // store column, up to 256 columns
  localparam int PFB_IDX_W       = 2;   // config register index

  // operation codes, same encoding as the mode input
  typedef enum logic [1:0] {
    OP_CLR_ALL  = 2'd0,
    OP_CLR_AREA = 2'd1,
    OP_BLIT     = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  // config register indexes
  typedef enum logic [PFB_IDX_W-1:0] {
    REG_ORIGIN_X     = 2'd0,
    REG_ORIGIN_Y     = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } cfg_reg_t;

  // config register file as seen by the back end
  typedef struct packed {
    logic [6:0] origin_x;
    logic [5:0] origin_y;
    logic [7:0] image_width;
    logic [6:0] image_height;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t                  op;
    logic                 ok0;    // first target byte inside the store
    logic                 ok1;    // spill byte present and inside the store
    logic [PFB_PG_W-1:0]  page;
    logic [PFB_COL_W-1:0] col;
    logic [PFB_BYTE_W-1:0] data0;
    logic [PFB_BYTE_W-1:0] data1;
  } cmd_t;

endpackage

// ===== design/page_framebuffer_blit.sv =====
// page_framebuffer_blit: top level of the page organised frame buffer
// depends on pfb_pkg, pfb_front, pfb_queue, pfb_back (and pfb_ram below it)
//
//   channel  direction  handshake           payload
//   cfg_     in         cfg_valid/ready     cfg_index, cfg_data
//   in_      in         in_valid/in_stall   in_mode, in_image_byte, in_page, in_column
//   out_     out        out_valid/out_stall out_read_data
//
// a blit writes a second page when the shifted byte spills into it; a
// clear-all writes every byte of the store, a clear-area reads and writes
// back each touched byte (none when the area is empty); the single write
// port of the frame store serialises these writes.
// reset: a clearing pass over all PAGES*COLUMNS bytes (1024 by default) zeroes
// the store; in_stall stays high meanwhile, config writes are still taken.
// stalls: a two-entry command queue and the output register let input and
// output stall independently of the store sequencer.
`timescale 1ns / 1ps

module page_framebuffer_blit #(
  parameter int PAGES   = pfb_pkg::PFB_PAGES,
  parameter int COLUMNS = pfb_pkg::PFB_COLUMNS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfb_pkg::PFB_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [7:0]                    in_image_byte,
  input  logic [2:0]                    in_page,
  input  logic [6:0]                    in_column,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_read_data
);

  import pfb_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd, pop_cmd;
  logic q_push, q_pop, q_full, q_empty;
  logic init_busy;

  // accept and classify
  pfb_front #(
    .PAGES   (PAGES),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_image_byte (in_image_byte),
    .in_page       (in_page),
    .in_column     (in_column),
    .init_busy     (init_busy),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (push_cmd),
    .cfg           (cfg)
  );

  // command queue
  pfb_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (PFB_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .pop       (q_pop),
    .pop_data  (pop_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  // store sequencer and result register
  pfb_back #(
    .PAGES   (PAGES),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_data        (pop_cmd),
    .q_pop         (q_pop),
    .init_busy     (init_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data)
  );

endmodule

// ===== design/pfb_ram.sv =====
// pfb_ram: generic single write port, single read port ram, registered read
// no dependencies
`timescale 1ns / 1ps

module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/pfb_queue.sv =====
// pfb_queue: short register queue decoupling the front end from the back end
// no dependencies
`timescale 1ns / 1ps

module pfb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/pfb_front.sv =====
// pfb_front: config registers, input acceptance and command classification
// depends on pfb_pkg
`timescale 1ns / 1ps

module pfb_front #(
  parameter int PAGES   = pfb_pkg::PFB_PAGES,
  parameter int COLUMNS = pfb_pkg::PFB_COLUMNS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // config write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfb_pkg::PFB_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [7:0]                    in_image_byte,
  input  logic [2:0]                    in_page,
  input  logic [6:0]                    in_column,
  // towards queue and back end
  input  logic                          init_busy,
  input  logic                          q_full,
  output logic                          q_push,
  output pfb_pkg::cmd_t                 q_data,
  output pfb_pkg::cfg_t                 cfg
);

  import pfb_pkg::*;

  localparam logic [4:0] PAGES_C   = 5'(PAGES);
  localparam logic [8:0] COLUMNS_C = 9'(COLUMNS);

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] shift;
  logic [4:0] tpage;
  logic [4:0] tpage_hi;
  logic [7:0] tcol;
  logic       tcol_ok;

  // config write, always ready
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:     cfg_nxt.origin_x     = cfg_data[6:0];
        REG_ORIGIN_Y:     cfg_nxt.origin_y     = cfg_data[5:0];
        REG_IMAGE_WIDTH:  cfg_nxt.image_width  = cfg_data;
        REG_IMAGE_HEIGHT: cfg_nxt.image_height = cfg_data[6:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= 7'd0;
      cfg_r.origin_y     <= 6'd0;
      cfg_r.image_width  <= 8'd128;
      cfg_r.image_height <= 7'd64;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

  // accept while the queue has room and the store is not being initialized
  assign in_stall = q_full || init_busy;
  assign q_push   = in_valid && !in_stall;

  // blit target position
  assign shift    = cfg_r.origin_y[2:0];
  assign tpage    = {2'b00, cfg_r.origin_y[5:3]} + {2'b00, in_page};
  assign tpage_hi = tpage + 5'd1;
  assign tcol     = {1'b0, cfg_r.origin_x} + {1'b0, in_column};
  assign tcol_ok  = {1'b0, tcol} < COLUMNS_C;

  // classify the transaction into a command
  always_comb begin
    q_data       = '0;
    q_data.op    = op_t'(in_mode);
    unique case (op_t'(in_mode))
      OP_BLIT: begin
        q_data.ok0   = (tpage < PAGES_C) && tcol_ok;
        q_data.ok1   = (shift != 3'd0) && (tpage_hi < PAGES_C) && tcol_ok;
        q_data.page  = tpage[PFB_PG_W-1:0];
        q_data.col   = tcol;
        q_data.data0 = in_image_byte << shift;
        q_data.data1 = in_image_byte >> (4'd8 - {1'b0, shift});
      end
      OP_READ: begin
        q_data.ok0  = ({2'b00, in_page} < PAGES_C) && ({2'b00, in_column} < COLUMNS_C);
        q_data.page = {1'b0, in_page};
        q_data.col  = {1'b0, in_column};
      end
      OP_CLR_ALL, OP_CLR_AREA: begin
        q_data.op = op_t'(in_mode);
      end
      default: begin
        q_data = '0;
      end
    endcase
  end

endmodule

// ===== design/pfb_back.sv =====
// pfb_back: sequencer that runs commands against the frame store and
// drives the result register; depends on pfb_pkg and pfb_ram
`timescale 1ns / 1ps

module pfb_back #(
  parameter int PAGES   = pfb_pkg::PFB_PAGES,
  parameter int COLUMNS = pfb_pkg::PFB_COLUMNS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pfb_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  pfb_pkg::cmd_t q_data,
  output logic          q_pop,
  output logic          init_busy,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_read_data
);

  import pfb_pkg::*;

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int ROWS  = PAGES * 8;
  localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
  localparam logic [7:0]    ROWS_C    = 8'(ROWS);
  localparam logic [8:0]    COLUMNS_C = 9'(COLUMNS);

  typedef enum logic [8:0] {
    ST_INIT      = 9'b000000001,
    ST_IDLE      = 9'b000000010,
    ST_SWEEP     = 9'b000000100,
    ST_AREA      = 9'b000001000,
    ST_AREA_LAST = 9'b000010000,
    ST_BLIT_A    = 9'b000100000,
    ST_BLIT_B    = 9'b001000000,
    ST_RD_WAIT   = 9'b010000000,
    ST_HOLD      = 9'b100000000
  } state_t;

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [AW-1:0]        cnt_r, cnt_nxt;
  logic [PFB_PG_W-1:0]  cur_page_r, cur_page_nxt;
  logic [PFB_COL_W-1:0] cur_col_r, cur_col_nxt;
  logic [AW-1:0]        wr_addr_r, wr_addr_nxt;
  logic [7:0]           wmask_r, wmask_nxt;
  logic                 pend_r, pend_nxt;
  logic [7:0]           res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_data_r, out_data_nxt;

  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [7:0]           wdata, rdata;
  logic                 fin;
  logic [7:0]           fin_data;
  logic                 out_free;

  // clear-area geometry derived from config
  logic [7:0]           row_end_raw, row_end, last_row;
  logic [8:0]           col_end_raw, col_end, col_end_m1;
  logic [PFB_COL_W-1:0] col_last;
  logic [PFB_PG_W-1:0]  first_page, last_page;
  logic                 area_empty;
  logic                 area_done;

  function automatic logic [AW-1:0] addr_of(logic [PFB_PG_W-1:0] pg,
                                            logic [PFB_COL_W-1:0] c);
    logic [31:0] t;
    t = 32'(pg) * 32'(COLUMNS) + 32'(c);
    return t[AW-1:0];
  endfunction

  function automatic logic [7:0] page_mask(logic [PFB_PG_W-1:0] pg,
                                           logic [PFB_PG_W-1:0] first_pg,
                                           logic [PFB_PG_W-1:0] last_pg,
                                           logic [2:0] top_bit,
                                           logic [2:0] bot_bit);
    logic [2:0] lo_n;
    logic [2:0] hi_n;
    lo_n = (pg == first_pg) ? top_bit : 3'd0;
    hi_n = (pg == last_pg) ? bot_bit : 3'd7;
    return (8'hFF << lo_n) & (8'hFF >> (3'd7 - hi_n));
  endfunction

  // frame store
  pfb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // clear-area bounds, clipped to the store
  assign row_end_raw = {2'b00, cfg.origin_y} + {1'b0, cfg.image_height};
  assign row_end     = (row_end_raw > ROWS_C) ? ROWS_C : row_end_raw;
  assign last_row    = row_end - 8'd1;
  assign col_end_raw = {2'b00, cfg.origin_x} + {1'b0, cfg.image_width};
  assign col_end     = (col_end_raw > COLUMNS_C) ? COLUMNS_C : col_end_raw;
  assign col_end_m1  = col_end - 9'd1;
  assign col_last    = col_end_m1[PFB_COL_W-1:0];
  assign first_page  = {1'b0, cfg.origin_y[5:3]};
  assign last_page   = last_row[6:3];
  assign area_empty  = (cfg.image_height == 7'd0) || (cfg.image_width == 8'd0) ||
                       ({2'b00, cfg.origin_y} >= ROWS_C) ||
                       ({2'b00, cfg.origin_x} >= COLUMNS_C);
  assign area_done   = (cur_page_r == last_page) && (cur_col_r == col_last);

  assign out_free  = !out_valid_r || !out_stall;
  assign init_busy = (state_r == ST_INIT);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    cnt_nxt      = cnt_r;
    cur_page_nxt = cur_page_r;
    cur_col_nxt  = cur_col_r;
    wr_addr_nxt  = wr_addr_r;
    wmask_nxt    = wmask_r;
    pend_nxt     = pend_r;
    res_nxt      = res_r;
    q_pop        = 1'b0;
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;
    re           = 1'b0;
    raddr        = '0;
    fin          = 1'b0;
    fin_data     = 8'd0;

    unique case (state_r)
      ST_INIT: begin
        we    = 1'b1;
        waddr = cnt_r;
        if (cnt_r == ADDR_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_data;
          unique case (q_data.op)
            OP_CLR_ALL: begin
              cnt_nxt   = '0;
              state_nxt = ST_SWEEP;
            end
            OP_CLR_AREA: begin
              if (area_empty) begin
                fin = 1'b1;
              end else begin
                cur_page_nxt = first_page;
                cur_col_nxt  = {1'b0, cfg.origin_x};
                pend_nxt     = 1'b0;
                state_nxt    = ST_AREA;
              end
            end
            OP_BLIT: begin
              re        = q_data.ok0;
              raddr     = addr_of(q_data.page, q_data.col);
              state_nxt = ST_BLIT_A;
            end
            OP_READ: begin
              re        = q_data.ok0;
              raddr     = addr_of(q_data.page, q_data.col);
              state_nxt = ST_RD_WAIT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_SWEEP: begin
        we    = 1'b1;
        waddr = cnt_r;
        if (cnt_r == ADDR_LAST) begin
          fin = 1'b1;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      // read one byte per cycle, write back the previous one masked
      ST_AREA: begin
        we          = pend_r;
        waddr       = wr_addr_r;
        wdata       = rdata & ~wmask_r;
        re          = 1'b1;
        raddr       = addr_of(cur_page_r, cur_col_r);
        wr_addr_nxt = addr_of(cur_page_r, cur_col_r);
        wmask_nxt   = page_mask(cur_page_r, first_page, last_page,
                                cfg.origin_y[2:0], last_row[2:0]);
        pend_nxt    = 1'b1;
        if (area_done) begin
          state_nxt = ST_AREA_LAST;
        end else if (cur_col_r == col_last) begin
          cur_col_nxt  = {1'b0, cfg.origin_x};
          cur_page_nxt = cur_page_r + PFB_PG_W'(1);
        end else begin
          cur_col_nxt = cur_col_r + PFB_COL_W'(1);
        end
      end

      ST_AREA_LAST: begin
        we    = 1'b1;
        waddr = wr_addr_r;
        wdata = rdata & ~wmask_r;
        fin   = 1'b1;
      end

      // merge low part, fetch the spill byte
      ST_BLIT_A: begin
        we    = cmd_r.ok0;
        waddr = addr_of(cmd_r.page, cmd_r.col);
        wdata = rdata | cmd_r.data0;
        if (cmd_r.ok1) begin
          re        = 1'b1;
          raddr     = addr_of(cmd_r.page + PFB_PG_W'(1), cmd_r.col);
          state_nxt = ST_BLIT_B;
        end else begin
          fin = 1'b1;
        end
      end

      ST_BLIT_B: begin
        we    = 1'b1;
        waddr = addr_of(cmd_r.page + PFB_PG_W'(1), cmd_r.col);
        wdata = rdata | cmd_r.data1;
        fin   = 1'b1;
      end

      ST_RD_WAIT: begin
        fin      = 1'b1;
        fin_data = cmd_r.ok0 ? rdata : 8'd0;
      end

      ST_HOLD: begin
        fin      = 1'b1;
        fin_data = res_r;
      end

      default: begin
        state_nxt = ST_INIT;
      end
    endcase

    // hand the result to the output register or park it
    if (fin) begin
      if (out_free) begin
        state_nxt = ST_IDLE;
      end else begin
        res_nxt   = fin_data;
        state_nxt = ST_HOLD;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (fin && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = fin_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cur_page_r <= cur_page_nxt;
    cur_col_r  <= cur_col_nxt;
    wr_addr_r  <= wr_addr_nxt;
    wmask_r    <= wmask_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule
